### design/cptb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cptb_pkg: shared types and constants for the cascading prescaled timer bank
// Holds the channel count, counter width, item mode codes and the control
// register layout used by the timer bank and its port checker.
// ----------------------------------------------------------------------------
package cptb_pkg;

	// Number of timer channels (1 to 4) and width of each counter (8 to 32).
	localparam int NUM_TIMERS  = 4;
	localparam int COUNT_WIDTH = 16;

	// Widths fixed by the item fields.
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 2;
	localparam int DATA_W  = 16;
	localparam int PULSE_W = 4;

	// Free-running prescale time base.
	localparam int TIME_W      = 10;
	localparam int IRQ_DELAY_W = 2;

	// Ticks from overflow to interrupt.
	localparam logic [IRQ_DELAY_W-1:0] IRQ_LATENCY = IRQ_DELAY_W'(3);

	// Bit positions in a control write.
	localparam int CTRL_CASCADE_BIT = 2;
	localparam int CTRL_IRQ_BIT     = 6;
	localparam int CTRL_ENABLE_BIT  = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK         = 2'd0,
		MODE_WRITE_RELOAD = 2'd1,
		MODE_WRITE_CTRL   = 2'd2,
		MODE_READ_COUNT   = 2'd3
	} mode_t;

	// Prescale selects: step every 1, 64, 256 or 1024 tick words.
	typedef enum logic [1:0] {
		PRESCALE_1    = 2'd0,
		PRESCALE_64   = 2'd1,
		PRESCALE_256  = 2'd2,
		PRESCALE_1024 = 2'd3
	} prescale_t;

	typedef struct packed {
		logic      enable;
		logic      irq_en;
		logic      cascade;
		prescale_t prescale;
	} ctrl_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// True when the new time value lands on a step boundary of the select.
	function automatic logic prescale_hit(input logic [TIME_W-1:0] t, input prescale_t sel);
		logic hit;
		case (sel)
			PRESCALE_1:    hit = 1'b1;
			PRESCALE_64:   hit = (t[5:0] == 6'd0);
			PRESCALE_256:  hit = (t[7:0] == 8'd0);
			PRESCALE_1024: hit = (t == '0);
			default:       hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage
`default_nettype wire

### design/cascading_prescaled_timer_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cascading_prescaled_timer_bank: reload timers with prescaler and cascade
// Four up-counting reload timers sharing a 10-bit tick time base, with
// overflow pulses, delayed interrupts and timer-to-timer cascading.
// ----------------------------------------------------------------------------
// The bank takes one word per clock cycle, unless stalled, and returns one result
// word for every word it takes, in order. A word is first captured in an input
// register; once the output register is free or being emptied, the whole tick,
// write or read is worked out in one pass (including the overflow ripple through
// the cascade chain) and the result is placed in the output register. The sustained
// rate is one word per cycle. The input side stalls only while a result waits in the
// output register and the receiver is stalling it. A tick word stands for one timer
// clock: the time base advances only on tick words, never on writes or reads.
module cascading_prescaled_timer_bank (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [cptb_pkg::MODE_W-1:0]    mode,
	input  wire logic [cptb_pkg::INDEX_W-1:0]   timer_index,
	input  wire logic [cptb_pkg::DATA_W-1:0]    write_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [cptb_pkg::DATA_W-1:0]         read_data,
	output logic [cptb_pkg::PULSE_W-1:0]        irq_pulses,
	output logic [cptb_pkg::PULSE_W-1:0]        overflow_pulses
);

	localparam int NT = cptb_pkg::NUM_TIMERS;

	// Input register.
	logic                             valid_s1;
	cptb_pkg::mode_t                  mode_s1;
	logic [cptb_pkg::INDEX_W-1:0]     index_s1;
	logic [cptb_pkg::DATA_W-1:0]      data_s1;

	// Timer state.
	cptb_pkg::count_t                 count_q  [NT];
	cptb_pkg::count_t                 reload_q [NT];
	cptb_pkg::ctrl_t                  ctrl_q   [NT];
	logic [NT-1:0]                    pending_q;
	logic [cptb_pkg::IRQ_DELAY_W-1:0] irq_delay_q [NT];
	logic [cptb_pkg::TIME_W-1:0]      time_q;

	// Next-state values.
	cptb_pkg::count_t                 count_d  [NT];
	cptb_pkg::count_t                 reload_d [NT];
	cptb_pkg::ctrl_t                  ctrl_d   [NT];
	logic [NT-1:0]                    pending_d;
	logic [cptb_pkg::IRQ_DELAY_W-1:0] irq_delay_d [NT];
	logic [cptb_pkg::TIME_W-1:0]      time_d;

	logic [cptb_pkg::DATA_W-1:0]      rd_d;
	logic [NT-1:0]                    irq_vec;
	logic [NT-1:0]                    ovf_vec;
	logic                             advance;

	// The held word moves on when the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1  <= cptb_pkg::mode_t'(mode);
			index_s1 <= timer_index;
			data_s1  <= write_data;
		end
	end

	// One pass over the held word: tick, reload write, control write or read.
	always_comb begin
		logic carry;
		logic in_carry;
		logic step;
		logic hit;
		cptb_pkg::ctrl_t c;

		count_d     = count_q;
		reload_d    = reload_q;
		ctrl_d      = ctrl_q;
		pending_d   = pending_q;
		irq_delay_d = irq_delay_q;
		time_d      = time_q;
		rd_d        = '0;
		irq_vec     = '0;
		ovf_vec     = '0;
		carry       = 1'b0;
		in_carry    = 1'b0;
		step        = 1'b0;
		hit         = 1'b0;
		c           = '0;

		unique case (mode_s1)
			cptb_pkg::MODE_TICK: begin
				time_d = time_q + 1'b1;
				for (int t = 0; t < NT; t++) begin
					// Interrupt delay counts down and fires on reaching zero.
					if (irq_delay_q[t] != '0) begin
						irq_delay_d[t] = irq_delay_q[t] - 1'b1;
						if (irq_delay_q[t] == cptb_pkg::IRQ_DELAY_W'(1)) begin
							irq_vec[t] = 1'b1;
						end
					end

					in_carry = carry;
					carry    = 1'b0;
					hit      = cptb_pkg::prescale_hit(time_d, ctrl_q[t].prescale);
					if (t > 0 && ctrl_q[t].cascade) begin
						step = in_carry;
					end else begin
						step = hit;
					end

					if (pending_q[t]) begin
						// A start loads the reload value and skips this step.
						count_d[t]   = reload_q[t];
						pending_d[t] = 1'b0;
					end else if (ctrl_q[t].enable && step) begin
						if (count_q[t] == '1) begin
							count_d[t] = reload_q[t];
							ovf_vec[t] = 1'b1;
							carry      = 1'b1;
							if (ctrl_q[t].irq_en) begin
								irq_delay_d[t] = cptb_pkg::IRQ_LATENCY;
							end
						end else begin
							count_d[t] = count_q[t] + 1'b1;
						end
					end
				end
			end
			cptb_pkg::MODE_WRITE_RELOAD: begin
				for (int t = 0; t < NT; t++) begin
					if (32'(index_s1) == t) begin
						reload_d[t] = cptb_pkg::COUNT_WIDTH'(data_s1);
					end
				end
			end
			cptb_pkg::MODE_WRITE_CTRL: begin
				for (int t = 0; t < NT; t++) begin
					if (32'(index_s1) == t) begin
						c.prescale = cptb_pkg::prescale_t'(data_s1[1:0]);
						c.cascade  = (t > 0) && data_s1[cptb_pkg::CTRL_CASCADE_BIT];
						c.irq_en   = data_s1[cptb_pkg::CTRL_IRQ_BIT];
						c.enable   = data_s1[cptb_pkg::CTRL_ENABLE_BIT];
						ctrl_d[t]  = c;
						// Clearing enable cancels a start; a rising enable arms one.
						if (!c.enable) begin
							pending_d[t] = 1'b0;
						end else if (!ctrl_q[t].enable) begin
							pending_d[t] = 1'b1;
						end
					end
				end
			end
			cptb_pkg::MODE_READ_COUNT: begin
				for (int t = 0; t < NT; t++) begin
					if (32'(index_s1) == t) begin
						rd_d = cptb_pkg::DATA_W'(count_q[t]);
					end
				end
			end
		endcase
	end

	// Timer state registers, updated when a word is worked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) begin
				count_q[t]     <= '0;
				reload_q[t]    <= '0;
				ctrl_q[t]      <= '0;
				irq_delay_q[t] <= '0;
			end
			pending_q <= '0;
			time_q    <= '0;
		end else if (advance) begin
			count_q     <= count_d;
			reload_q    <= reload_d;
			ctrl_q      <= ctrl_d;
			irq_delay_q <= irq_delay_d;
			pending_q   <= pending_d;
			time_q      <= time_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data       <= rd_d;
			irq_pulses      <= cptb_pkg::PULSE_W'(irq_vec);
			overflow_pulses <= cptb_pkg::PULSE_W'(ovf_vec);
		end
	end

endmodule
`default_nettype wire

### design/cptb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cptb_checker: port-level checks for the cascading prescaled timer bank
// Watches the handshakes and result words at the top level's ports.
// ----------------------------------------------------------------------------
module cptb_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [cptb_pkg::DATA_W-1:0]    read_data,
	input wire logic [cptb_pkg::PULSE_W-1:0]   irq_pulses,
	input wire logic [cptb_pkg::PULSE_W-1:0]   overflow_pulses
);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data)
			&& $stable(irq_pulses) && $stable(overflow_pulses))
		else $error("stalled result word changed");

	// The input side stalls only behind a stalled result.
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// A word taken reaches the output once the output side is free.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted word did not reach the output");

	// A result with nonzero read data carries no tick pulses.
	a_read_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_data != '0) |-> (irq_pulses == '0) && (overflow_pulses == '0))
		else $error("read word carries timer pulses");

endmodule

bind cascading_prescaled_timer_bank cptb_checker u_cptb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.read_data       (read_data),
	.irq_pulses      (irq_pulses),
	.overflow_pulses (overflow_pulses)
);
`default_nettype wire

### test/cascading_prescaled_timer_bank_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascading_prescaled_timer_bank_tb: self-checking bench for the timer bank
// Feeds tick, reload, control and read words through the valid/stall input
// channel, predicts every result word from a local model of the four timers,
// and compares each accepted result field by field, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module cascading_prescaled_timer_bank_tb;

	localparam int WORD_TARGET    = 1850;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int CALM_FROM      = 700;
	localparam int CALM_TO        = 1200;

	// One input word and one result word.
	typedef struct {
		cptb_pkg::mode_t                 mode;
		logic [cptb_pkg::INDEX_W-1:0]    idx;
		logic [cptb_pkg::DATA_W-1:0]     data;
	} bank_word_t;

	typedef struct {
		logic [cptb_pkg::DATA_W-1:0]     rd;
		logic [cptb_pkg::PULSE_W-1:0]    irq;
		logic [cptb_pkg::PULSE_W-1:0]    ovf;
	} bank_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [cptb_pkg::MODE_W-1:0]      mode = '0;
	logic [cptb_pkg::INDEX_W-1:0]     timer_index = '0;
	logic [cptb_pkg::DATA_W-1:0]      write_data = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [cptb_pkg::DATA_W-1:0]      read_data;
	logic [cptb_pkg::PULSE_W-1:0]     irq_pulses;
	logic [cptb_pkg::PULSE_W-1:0]     overflow_pulses;

	bank_word_t   word_queue[$];
	bank_result_t awaited_results[$];

	// Local copy of the timer state.
	cptb_pkg::count_t                    count_q [cptb_pkg::NUM_TIMERS];
	cptb_pkg::count_t                    reload_q [cptb_pkg::NUM_TIMERS];
	cptb_pkg::ctrl_t                     ctrl_q [cptb_pkg::NUM_TIMERS];
	logic [cptb_pkg::TIME_W-1:0]         time_q;
	logic                                start_q [cptb_pkg::NUM_TIMERS];
	logic [cptb_pkg::IRQ_DELAY_W-1:0]    irq_wait_q [cptb_pkg::NUM_TIMERS];

	int mismatch_count = 0;
	int cycle_count = 0;
	int quiet_cycles = 0;
	int tick_words = 0;
	int write_words = 0;
	int read_words = 0;
	int overflows_seen = 0;
	int irqs_seen = 0;

	cascading_prescaled_timer_bank i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.timer_index     (timer_index),
		.write_data      (write_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.irq_pulses      (irq_pulses),
		.overflow_pulses (overflow_pulses)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Random idling, switched off for one stretch of the run.
	function automatic logic take_break();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
			return 1'b0;
		return ($urandom_range(0, 99) < 10);
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH: %s", msg);
	endtask

	// Apply one word to the local timer state and work out its result word.
	task automatic timer_bank_update(input bank_word_t w, output bank_result_t r);
		logic                           carry;
		logic                           in_carry;
		logic                           stepping;
		logic                           was_on;
		logic                           started [cptb_pkg::NUM_TIMERS];
		logic [cptb_pkg::TIME_W-1:0]    step_mask;
		cptb_pkg::ctrl_t                nc;
		int unsigned                    ix;
		r = '{rd: '0, irq: '0, ovf: '0};
		ix = w.idx;
		case (w.mode)
			cptb_pkg::MODE_TICK: begin
				time_q = time_q + 1'b1;
				// Pending interrupts count down first.
				for (int t = 0; t < cptb_pkg::NUM_TIMERS; t++) begin
					if (irq_wait_q[t] != '0) begin
						irq_wait_q[t] = irq_wait_q[t] - 1'b1;
						if (irq_wait_q[t] == '0 && t < cptb_pkg::PULSE_W)
							r.irq[t] = 1'b1;
					end
				end
				// A pending start loads the reload value and skips this step.
				for (int t = 0; t < cptb_pkg::NUM_TIMERS; t++) begin
					started[t] = start_q[t];
					if (start_q[t])
						count_q[t] = reload_q[t];
					start_q[t] = 1'b0;
				end
				// Step each timer in order so that overflows ripple upwards.
				carry = 1'b0;
				for (int t = 0; t < cptb_pkg::NUM_TIMERS; t++) begin
					in_carry = carry;
					carry = 1'b0;
					if (ctrl_q[t].enable && !started[t]) begin
						if (t > 0 && ctrl_q[t].cascade) begin
							stepping = in_carry;
						end else begin
							case (ctrl_q[t].prescale)
								cptb_pkg::PRESCALE_1:   step_mask = '0;
								cptb_pkg::PRESCALE_64:  step_mask = 10'h03F;
								cptb_pkg::PRESCALE_256: step_mask = 10'h0FF;
								default:                step_mask = 10'h3FF;
							endcase
							stepping = ((time_q & step_mask) == '0);
						end
						if (stepping) begin
							if (count_q[t] == '1) begin
								count_q[t] = reload_q[t];
								if (t < cptb_pkg::PULSE_W)
									r.ovf[t] = 1'b1;
								if (ctrl_q[t].irq_en)
									irq_wait_q[t] = cptb_pkg::IRQ_LATENCY;
								carry = 1'b1;
							end else begin
								count_q[t] = count_q[t] + 1'b1;
							end
						end
					end
				end
			end
			cptb_pkg::MODE_WRITE_RELOAD: begin
				if (ix < cptb_pkg::NUM_TIMERS)
					reload_q[ix] = cptb_pkg::COUNT_WIDTH'(w.data);
			end
			cptb_pkg::MODE_WRITE_CTRL: begin
				if (ix < cptb_pkg::NUM_TIMERS) begin
					was_on = ctrl_q[ix].enable;
					nc.prescale = cptb_pkg::prescale_t'(w.data[1:0]);
					nc.cascade  = w.data[cptb_pkg::CTRL_CASCADE_BIT] && (ix != 0);
					nc.irq_en   = w.data[cptb_pkg::CTRL_IRQ_BIT];
					nc.enable   = w.data[cptb_pkg::CTRL_ENABLE_BIT];
					ctrl_q[ix] = nc;
					if (!nc.enable)
						start_q[ix] = 1'b0;
					else if (!was_on)
						start_q[ix] = 1'b1;
				end
			end
			default: begin
				if (ix < cptb_pkg::NUM_TIMERS)
					r.rd = cptb_pkg::DATA_W'(count_q[ix]);
			end
		endcase
	endtask

	task automatic queue_word(input cptb_pkg::mode_t m, input int unsigned idx,
		input int unsigned data);
		bank_word_t w;
		w.mode = m;
		w.idx  = cptb_pkg::INDEX_W'(idx);
		w.data = cptb_pkg::DATA_W'(data);
		word_queue.push_back(w);
	endtask

	// Reload values lean towards the top of the range so that overflows come often.
	function automatic int unsigned pick_reload();
		case ($urandom_range(0, 3))
			0, 1: return 32'hFFFF - $urandom_range(0, 15);
			2:    return $urandom_range(0, 32'hFFFF);
			default: return $urandom_range(0, 1) ? 32'hFFFF : 32'h0000;
		endcase
	endfunction

	// Control words are mostly enabling, often with the fastest prescale.
	function automatic int unsigned pick_ctrl();
		logic [cptb_pkg::DATA_W-1:0] d;
		d = cptb_pkg::DATA_W'($urandom_range(0, 32'hFFFF));
		if ($urandom_range(0, 9) < 7)
			d[cptb_pkg::CTRL_ENABLE_BIT] = 1'b1;
		if ($urandom_range(0, 1) == 0)
			d[1:0] = cptb_pkg::PRESCALE_1;
		return 32'(d);
	endfunction

	// Driver: predicts each accepted word, then presents the next one.
	always @(posedge clk or negedge arst_n) begin
		bank_word_t   w;
		bank_result_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (in_valid && !in_stall) begin
				w.mode = cptb_pkg::mode_t'(mode);
				w.idx  = timer_index;
				w.data = write_data;
				timer_bank_update(w, r);
				awaited_results.push_back(r);
				case (w.mode)
					cptb_pkg::MODE_TICK:       tick_words++;
					cptb_pkg::MODE_READ_COUNT: read_words++;
					default:                   write_words++;
				endcase
			end
			if (!in_valid || !in_stall) begin
				if (word_queue.size() != 0 && !take_break()) begin
					w = word_queue.pop_front();
					mode        <= w.mode;
					timer_index <= w.idx;
					write_data  <= w.data;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		bank_result_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				overflows_seen += $countones(overflow_pulses);
				irqs_seen += $countones(irq_pulses);
				if (awaited_results.size() == 0) begin
					flag_mismatch("result word arrived with nothing outstanding");
				end else begin
					e = awaited_results.pop_front();
					if (read_data !== e.rd)
						flag_mismatch($sformatf("read_data got %h expected %h",
							read_data, e.rd));
					if (irq_pulses !== e.irq)
						flag_mismatch($sformatf("irq_pulses got %b expected %b",
							irq_pulses, e.irq));
					if (overflow_pulses !== e.ovf)
						flag_mismatch($sformatf("overflow_pulses got %b expected %b",
							overflow_pulses, e.ovf));
				end
			end
			out_stall <= take_break();
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned tmr;
		int unsigned burst;
		int unsigned roll;
		for (int t = 0; t < cptb_pkg::NUM_TIMERS; t++) begin
			count_q[t]    = '0;
			reload_q[t]   = '0;
			ctrl_q[t]     = '0;
			start_q[t]    = 1'b0;
			irq_wait_q[t] = '0;
		end
		time_q = '0;

		// Directed opening: reset values, a fast cascade pair, repeated overflows,
		// clearing irq enable with an interrupt pending, timer zero ignoring its
		// cascade bit, disable while a start is pending, and all control bits set.
		queue_word(cptb_pkg::MODE_READ_COUNT, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_WRITE_RELOAD, 0, 32'hFFFF);
		queue_word(cptb_pkg::MODE_WRITE_RELOAD, 1, 32'hFFFE);
		queue_word(cptb_pkg::MODE_WRITE_CTRL, 0, 32'h00C4);
		queue_word(cptb_pkg::MODE_WRITE_CTRL, 1, 32'h00C4);
		queue_word(cptb_pkg::MODE_TICK, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_TICK, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_TICK, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_WRITE_CTRL, 0, 32'h0080);
		queue_word(cptb_pkg::MODE_TICK, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_TICK, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_TICK, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_WRITE_CTRL, 2, 32'h0083);
		queue_word(cptb_pkg::MODE_WRITE_CTRL, 2, 32'h0000);
		queue_word(cptb_pkg::MODE_TICK, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_READ_COUNT, 2, 32'h0000);
		queue_word(cptb_pkg::MODE_WRITE_RELOAD, 3, 32'h0000);
		queue_word(cptb_pkg::MODE_WRITE_CTRL, 3, 32'hFFFF);
		queue_word(cptb_pkg::MODE_TICK, 3, 32'hFFFF);
		queue_word(cptb_pkg::MODE_READ_COUNT, 3, 32'h0000);
		queue_word(cptb_pkg::MODE_READ_COUNT, 1, 32'hFFFF);
		queue_word(cptb_pkg::MODE_WRITE_CTRL, 0, 32'h0000);
		queue_word(cptb_pkg::MODE_READ_COUNT, 0, 32'h0000);

		// Random part: mostly a timer being programmed, sometimes one to four unstructured
		// words, then in either case a burst of ticks with reads and some writes mixed in.
		while (word_queue.size() < WORD_TARGET) begin
			tmr = $urandom_range(0, cptb_pkg::NUM_TIMERS - 1);
			if ($urandom_range(0, 9) < 7) begin
				queue_word(cptb_pkg::MODE_WRITE_RELOAD, tmr, pick_reload());
				queue_word(cptb_pkg::MODE_WRITE_CTRL, tmr, pick_ctrl());
			end else begin
				repeat ($urandom_range(1, 4))
					queue_word(cptb_pkg::mode_t'($urandom_range(0, 3)),
						$urandom_range(0, 3), $urandom_range(0, 32'hFFFF));
			end
			burst = ($urandom_range(0, 15) == 0) ? $urandom_range(150, 400)
				: $urandom_range(1, 60);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < 75)
					queue_word(cptb_pkg::MODE_TICK, $urandom_range(0, 3),
						$urandom_range(0, 32'hFFFF));
				else if (roll < 92)
					queue_word(cptb_pkg::MODE_READ_COUNT, $urandom_range(0, 3),
						$urandom_range(0, 32'hFFFF));
				else if (roll < 96)
					queue_word(cptb_pkg::MODE_WRITE_RELOAD, $urandom_range(0, 3),
						pick_reload());
				else
					queue_word(cptb_pkg::MODE_WRITE_CTRL, $urandom_range(0, 3),
						pick_ctrl());
			end
		end

		// Cut the last burst short so that the run sends the planned number of words.
		while (word_queue.size() > WORD_TARGET)
			void'(word_queue.pop_back());

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word to go in and every result to come out.
		while (word_queue.size() != 0 || in_valid)
			@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d tick, %0d write and %0d read words", tick_words,
			write_words, read_words);
		$display("saw %0d overflow pulses and %0d interrupt pulses, %0d mismatches",
			overflows_seen, irqs_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
design/cptb_pkg.sv
design/cascading_prescaled_timer_bank.sv
design/cptb_checker.sv
test/cascading_prescaled_timer_bank_tb.sv
